// File: sv/pgrs_pkg.sv
// Shared constants, types and sequencer states for the PCM gain ramp scaler.
// No dependencies; compile first.
package pgrs_pkg;

  localparam int FRAME_BYTES  = 4;
  localparam int UNITY_GAIN   = 32768;
  localparam int MAX_FRAMES   = 4096;
  localparam int SAMPLE_BYTES = 2;
  localparam int BYTE_BITS    = 8;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int FRAMES_W = 13;
  localparam int POS_W    = 14;
  localparam int OFFS_W   = POS_W + $clog2(SAMPLE_BYTES) + 1;
  localparam int FRAME_W  = POS_W;
  localparam int PROD_W   = 2 * GAIN_W;
  localparam int NUM_W    = GAIN_W + FRAME_W;
  localparam int DIVC_W   = $clog2(NUM_W + 1);
  localparam int UNITY_SH = $clog2(UNITY_GAIN);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIV,
    ST_GAIN,
    ST_SCALE,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/pgrs_in_if.sv
// Input channel: one PCM sample with its block gains and frame count.
// Depends on pgrs_pkg.
interface pgrs_in_if;
  import pgrs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_W-1:0]   in_sample;
  logic        [GAIN_W-1:0]     start_gain;
  logic        [GAIN_W-1:0]     end_gain;
  logic        [FRAMES_W-1:0]   block_frames;
  logic                         half_byte;
  logic                         last;

  modport source (output valid, in_sample, start_gain, end_gain, block_frames,
                  half_byte, last, input ready);
  modport sink (input valid, in_sample, start_gain, end_gain, block_frames,
                half_byte, last, output ready);
endinterface

// File: sv/pgrs_out_if.sv
// Output channel: one scaled sample with its block markers.
// Depends on pgrs_pkg.
interface pgrs_out_if;
  import pgrs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_half_byte;
  logic                       out_last;

  modport source (output valid, out_sample, out_half_byte, out_last, input ready);
  modport sink (input valid, out_sample, out_half_byte, out_last, output ready);
endinterface

// File: sv/pgrs_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on pgrs_pkg.
module pgrs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pgrs_pkg::NUM_W-1:0]    num,
  input  logic [pgrs_pkg::FRAMES_W-1:0] den,
  output logic [pgrs_pkg::NUM_W-1:0]    quot,
  output pgrs_pkg::div_stat_t           stat
);
  import pgrs_pkg::*;

  logic [FRAMES_W-1:0] rem;
  logic [NUM_W-1:0]    qn;
  logic [FRAMES_W-1:0] divisor;
  logic [DIVC_W-1:0]   cnt;
  logic                busy;
  logic                done;

  logic [FRAMES_W:0]   trial;
  logic                fits;

  always_comb begin
    trial = {rem, qn[NUM_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIVC_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIVC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      qn      <= num;
      divisor <= den;
    end else if (busy) begin
      // shift in the next numerator bit, subtract when it fits
      if (fits) begin
        rem <= FRAMES_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[FRAMES_W-1:0];
      end
      qn <= {qn[NUM_W-2:0], fits};
    end
  end

  assign quot      = qn;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: sv/pcm_gain_ramp_scaler_core.sv
// Linear gain ramp over a block of 16-bit PCM samples. One sample is taken at a time; the
// next is accepted once the current one has reached the output register. A ramped sample
// (gains differ, frame count nonzero) waits in the sequencer on the 30-step serial divider
// that forms span * frame / frames. A flat-gain sample skips the divider, and a trailing
// half byte goes straight to the output step. A finished result may wait in the output
// register while the next sample is taken. A result that finds the register still full
// holds the sequencer in its output step.
// Depends on pgrs_pkg, pgrs_in_if, pgrs_out_if and pgrs_div.
module pcm_gain_ramp_scaler_core (
  input  logic clk,
  input  logic rst,
  pgrs_in_if.sink    stream,
  pgrs_out_if.source scaled
);
  import pgrs_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  logic [POS_W-1:0]           pos;
  logic signed [SAMPLE_W-1:0] sample;
  logic [GAIN_W-1:0]          start_g;
  logic [GAIN_W-1:0]          end_g;
  logic [FRAMES_W-1:0]        frames;
  logic [FRAME_W-1:0]         frame;
  logic                       half;
  logic                       blk_last;
  logic                       ramp;
  logic                       span_neg;
  logic [GAIN_W-1:0]          gain;
  logic [PROD_W-1:0]          prod;

  logic                       ovalid;
  logic signed [SAMPLE_W-1:0] osample;
  logic                       ohalf;
  logic                       olast;

  logic                       accept;
  logic                       out_free;
  logic [OFFS_W-1:0]          offset;
  logic [FRAMES_W-1:0]        frames_clamped;
  logic signed [GAIN_W:0]     span;
  logic [GAIN_W-1:0]          span_mag;
  logic                       ramp_now;
  logic [GAIN_W-1:0]          mult_a;
  logic [GAIN_W-1:0]          mult_b;
  logic [PROD_W-1:0]          mult_out;
  logic [GAIN_W-1:0]          sample_mag;
  logic [NUM_W:0]             gain_sum;
  logic [GAIN_W-1:0]          gain_new;
  logic [PROD_W:0]            rounded;
  logic [PROD_W-UNITY_SH:0]   q;
  logic signed [SAMPLE_W-1:0] result;
  logic                       div_start;
  logic [NUM_W-1:0]           quot;
  div_stat_t                  div_stat;

  assign accept   = stream.valid && stream.ready;
  assign out_free = !ovalid || scaled.ready;

  // Byte offset of the sample position and clamped frame count of the incoming sample
  always_comb begin
    offset = OFFS_W'(pos) * OFFS_W'(SAMPLE_BYTES);
    if (32'(stream.block_frames) > 32'(MAX_FRAMES)) begin
      frames_clamped = FRAMES_W'(MAX_FRAMES);
    end else begin
      frames_clamped = stream.block_frames;
    end
  end

  always_comb begin
    span     = $signed({1'b0, end_g}) - $signed({1'b0, start_g});
    span_mag = span[GAIN_W] ? GAIN_W'(-span) : span[GAIN_W-1:0];
    ramp_now = (span != '0) && (frames != '0);
    sample_mag = sample[SAMPLE_W-1] ? GAIN_W'(16'd0 - sample) : GAIN_W'(sample);
  end

  // One shared multiplier: span by frame first, then sample by gain
  always_comb begin
    if (state == ST_SPAN) begin
      mult_a = span_mag;
      mult_b = GAIN_W'(frame);
    end else begin
      mult_a = sample_mag;
      mult_b = gain;
    end
    mult_out = PROD_W'(mult_a) * PROD_W'(mult_b);
  end

  assign div_start = (state == ST_SPAN) && ramp_now;

  pgrs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NUM_W'(mult_out)),
    .den   (frames),
    .quot  (quot),
    .stat  (div_stat)
  );

  // Ramp gain with saturation to the gain range
  always_comb begin
    gain_sum = '0;
    if (span_neg) begin
      if (quot > NUM_W'(start_g)) begin
        gain_new = '0;
      end else begin
        gain_new = GAIN_W'(start_g - quot[GAIN_W-1:0]);
      end
    end else begin
      gain_sum = (NUM_W + 1)'(start_g) + (NUM_W + 1)'(quot);
      if (gain_sum > (NUM_W + 1)'(GAIN_MAX)) begin
        gain_new = GAIN_MAX;
      end else begin
        gain_new = gain_sum[GAIN_W-1:0];
      end
    end
  end

  // Round half away from zero, drop the unity scale, saturate; a half byte passes its low byte
  always_comb begin
    rounded = (PROD_W + 1)'(prod) + (PROD_W + 1)'(UNITY_GAIN / 2);
    q       = rounded[PROD_W:UNITY_SH];
    if (half) begin
      result = SAMPLE_W'(sample[BYTE_BITS-1:0]);
    end else if (sample[SAMPLE_W-1]) begin
      if (q > (PROD_W - UNITY_SH + 1)'(32768)) begin
        result = 16'sh8000;
      end else begin
        result = SAMPLE_W'(16'd0 - q[SAMPLE_W-1:0]);
      end
    end else if (q > (PROD_W - UNITY_SH + 1)'(32767)) begin
      result = 16'sh7fff;
    end else begin
      result = SAMPLE_W'(q[SAMPLE_W-1:0]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = stream.half_byte ? ST_OUT : ST_SPAN;
        end
      end
      ST_SPAN:  state_next = ramp_now ? ST_DIV : ST_SCALE;
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stream.ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (stream.last) begin
          pos <= '0;
        end else if (pos != POS_MAX) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample   <= stream.in_sample;
      start_g  <= stream.start_gain;
      end_g    <= stream.end_gain;
      frames   <= frames_clamped;
      frame    <= FRAME_W'(offset / FRAME_BYTES);
      half     <= stream.half_byte;
      blk_last <= stream.last;
    end
    if (state == ST_SPAN) begin
      ramp     <= ramp_now;
      span_neg <= span[GAIN_W];
      if (!ramp_now) begin
        gain <= end_g;
      end
    end
    if (state == ST_GAIN) begin
      gain <= gain_new;
    end
    if (state == ST_SCALE) begin
      prod <= mult_out;
    end
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      ovalid <= 1'b1;
    end else if (scaled.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      osample <= result;
      ohalf   <= half;
      olast   <= blk_last;
    end
  end

  assign scaled.valid         = ovalid;
  assign scaled.out_sample    = osample;
  assign scaled.out_half_byte = ohalf;
  assign scaled.out_last      = olast;

  a_last_clears_pos: assert property (@(posedge clk) disable iff (rst)
    (accept && stream.last) |=> (pos == '0))
    else $error("sample position not cleared after last item");

  a_pos_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && !stream.last && pos != POS_MAX) |=> (pos == $past(pos) + 1'b1))
    else $error("sample position did not advance");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide step");

  a_flat_gain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE && !ramp) |-> (gain == end_g))
    else $error("flat gain differs from end gain");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for pcm_gain_ramp_scaler_core: drives PCM sample transfers, predicts
// each scaled result from a model of the gain ramp, and compares every output transfer.
// Depends on pgrs_pkg, pgrs_in_if, pgrs_out_if and the core with its divider.
`timescale 1ns / 1ps

module testbench;
  import pgrs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_RUN = 150;
  localparam int PHASE_QUOTA = 360;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          start_gain;
    logic [GAIN_W-1:0]          end_gain;
    logic [FRAMES_W-1:0]        block_frames;
    logic                       half_byte;
    logic                       last;
  } pcm_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pcm;
    logic                half_byte;
    logic                last;
  } scaled_pcm_t;

  typedef struct packed {
    pcm_in_t             item;
    logic                fixed;
    logic [SAMPLE_W-1:0] want;
  } pcm_row_t;

  localparam logic [SAMPLE_W-1:0] EXTREME_SAMPLES [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

  // Directed rows; want is typed in only where fixed is set.
  localparam int N_ROWS = 22;
  localparam pcm_row_t DIRECTED_ROWS [N_ROWS] = '{
    // flat gain: unity, maximum, zero, rounding at the half
    '{'{16'h7FFF, 16'd32768, 16'd32768, 13'd0, 1'b0, 1'b0}, 1'b1, 16'h7FFF},
    '{'{16'h8000, 16'd32768, 16'd32768, 13'd0, 1'b0, 1'b0}, 1'b1, 16'h8000},
    '{'{16'h7FFF, 16'd65535, 16'd65535, 13'd0, 1'b0, 1'b0}, 1'b1, 16'h7FFF},
    '{'{16'h8000, 16'd65535, 16'd65535, 13'd0, 1'b0, 1'b0}, 1'b1, 16'h8000},
    '{'{16'd12345, 16'd0, 16'd0, 13'd0, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{16'hFFFF, 16'd32768, 16'd32768, 13'd0, 1'b0, 1'b0}, 1'b1, 16'hFFFF},
    '{'{16'h0001, 16'd16384, 16'd16384, 13'd0, 1'b0, 1'b0}, 1'b1, 16'h0001},
    '{'{16'hFFFF, 16'd16384, 16'd16384, 13'd0, 1'b0, 1'b0}, 1'b1, 16'hFFFF},
    '{'{16'h0001, 16'd16383, 16'd16383, 13'd0, 1'b0, 1'b0}, 1'b1, 16'h0000},
    // gains differ but no whole frames: end gain used flat
    '{'{16'd1000, 16'd0, 16'd32768, 13'd0, 1'b0, 1'b0}, 1'b1, 16'd1000},
    // trailing half byte, then one closing the block
    '{'{16'hA5C3, 16'd0, 16'd65535, 13'd5, 1'b1, 1'b0}, 1'b1, 16'h00C3},
    '{'{16'hFFFF, 16'd65535, 16'd0, 13'd5, 1'b1, 1'b1}, 1'b1, 16'h00FF},
    // ramp over one frame, then extrapolation past the block end
    '{'{16'h7FFF, 16'd0, 16'd65535, 13'd1, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{16'h7FFF, 16'd0, 16'd65535, 13'd1, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{16'd20000, 16'd0, 16'd65535, 13'd1, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{16'hB1E0, 16'd0, 16'd65535, 13'd1, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{16'hB1E0, 16'd0, 16'd65535, 13'd1, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{16'd30000, 16'd65535, 16'd0, 13'd1, 1'b0, 1'b0}, 1'b0, 16'h0000},
    // oversized frame count, falling ramp truncated toward zero
    '{'{16'd30000, 16'd0, 16'd65535, 13'd8191, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{16'd30000, 16'd100, 16'd50, 13'd4096, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{16'd30000, 16'd1000, 16'd0, 13'd7, 1'b0, 1'b1}, 1'b0, 16'h0000},
    '{'{16'h5A5A, 16'd12345, 16'd54321, 13'h1555, 1'b0, 1'b1}, 1'b0, 16'h0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pgrs_in_if  stream_if ();
  pgrs_out_if scaled_if ();

  pcm_gain_ramp_scaler_core uut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .scaled (scaled_if)
  );

  scaled_pcm_t       expected_scaled [$];
  logic [POS_W-1:0]  block_pos = '0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  bit                hold_request = 1'b0;
  bit                hold_taken = 1'b0;
  int                hold_left = 0;
  int                error_count = 0;
  int                results_checked = 0;
  int                ramped_count = 0;
  int                half_count = 0;
  int                directed_count = 0;
  int                long_count = 0;
  int                random_count = 0;
  int                cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_scaled.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Ramp gain for the current sample position, saturated to the gain range.
  function automatic longint ramp_gain_at(input logic [POS_W-1:0] pos, input pcm_in_t it);
    longint frame_idx, span, frames, g;
    frame_idx = (longint'(pos) * SAMPLE_BYTES) / FRAME_BYTES;
    span = longint'(it.end_gain) - longint'(it.start_gain);
    frames = (it.block_frames > MAX_FRAMES) ? longint'(MAX_FRAMES) : longint'(it.block_frames);
    if (span == 0 || frames == 0) return longint'(it.end_gain);
    g = longint'(it.start_gain) + (span * frame_idx) / frames;
    if (g < 0) g = 0;
    if (g > longint'(GAIN_MAX)) g = longint'(GAIN_MAX);
    return g;
  endfunction

  // Round the magnitude half away from zero, divide by unity and saturate.
  function automatic logic [SAMPLE_W-1:0] scaled_value(input logic signed [SAMPLE_W-1:0] smp,
                                                       input longint gain);
    longint mag, q;
    mag = (smp < 0) ? -longint'(smp) : longint'(smp);
    q = (mag * gain + UNITY_GAIN / 2) / UNITY_GAIN;
    if (smp < 0) begin
      if (q > 32768) q = 32768;
      return SAMPLE_W'(-q);
    end
    if (q > 32767) q = 32767;
    return SAMPLE_W'(q);
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("MISMATCH at cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Offer one sample, hold it until transferred, then log its expected result.
  task automatic send_pcm(input pcm_in_t it, input logic fixed, input logic [SAMPLE_W-1:0] want);
    scaled_pcm_t exp_res;
    while ($urandom_range(99) < tx_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid        <= 1'b1;
    stream_if.in_sample    <= it.sample;
    stream_if.start_gain   <= it.start_gain;
    stream_if.end_gain     <= it.end_gain;
    stream_if.block_frames <= it.block_frames;
    stream_if.half_byte    <= it.half_byte;
    stream_if.last         <= it.last;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    if (it.half_byte) begin
      exp_res.pcm = {8'h00, it.sample[7:0]};
      half_count++;
    end else begin
      exp_res.pcm = scaled_value(it.sample, ramp_gain_at(block_pos, it));
      if (it.start_gain != it.end_gain && it.block_frames != 0) ramped_count++;
    end
    if (fixed) exp_res.pcm = want;
    exp_res.half_byte = it.half_byte;
    exp_res.last = it.last;
    expected_scaled.push_back(exp_res);
    if (it.last) block_pos = '0;
    else if (block_pos != POS_MAX) block_pos = block_pos + 1'b1;
  endtask

  task automatic drain_results();
    stream_if.valid <= 1'b0;
    while (expected_scaled.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One block of random content: mostly well formed, some with a bogus frame count,
  // stray half bytes or last flags, or no closing last at all.
  task automatic send_random_block();
    int kind, nbytes, n_items;
    bit final_item;
    pcm_in_t it;
    kind = $urandom_range(99);
    nbytes = ($urandom_range(15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    n_items = nbytes / SAMPLE_BYTES + nbytes % 2;
    case ($urandom_range(9))
      0, 1: begin
        it.start_gain = GAIN_W'($urandom_range(0, 65535));
        it.end_gain = it.start_gain;
      end
      2: begin
        it.start_gain = $urandom_range(1) ? GAIN_MAX : '0;
        it.end_gain = $urandom_range(1) ? GAIN_MAX : GAIN_W'(UNITY_GAIN);
      end
      default: begin
        it.start_gain = GAIN_W'($urandom_range(0, 65535));
        it.end_gain = GAIN_W'($urandom_range(0, 65535));
      end
    endcase
    it.block_frames = (kind < 10) ? FRAMES_W'($urandom_range(0, 8191))
                                  : FRAMES_W'(nbytes / FRAME_BYTES);
    for (int i = 0; i < n_items; i++) begin
      final_item = (i == n_items - 1);
      it.sample = ($urandom_range(7) == 0) ? EXTREME_SAMPLES[$urandom_range(3)]
                                           : SAMPLE_W'($urandom);
      it.half_byte = (final_item && nbytes % 2 == 1) ||
                     (kind >= 10 && kind < 14 && $urandom_range(7) == 0);
      it.last = (final_item && !(kind >= 14 && kind < 20)) ||
                (kind >= 20 && kind < 24 && $urandom_range(7) == 0);
      send_pcm(it, 1'b0, '0);
      random_count++;
    end
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int quota,
                                  input bit pause_mid, input bit hold_mid);
    int first;
    first = random_count;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (random_count - first < quota) begin
      if (random_count - first >= quota / 2) begin
        // with pause_mid the sender stops until everything in flight has come out
        if (pause_mid) drain_results();
        if (hold_mid) hold_request = 1'b1;
        pause_mid = 1'b0;
        hold_mid = 1'b0;
      end
      send_random_block();
    end
  endtask

  // Receiver: random back-pressure, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) begin
      scaled_if.ready <= 1'b0;
      hold_left--;
    end else begin
      scaled_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    scaled_pcm_t want;
    if (!rst && scaled_if.valid && scaled_if.ready) begin
      if (expected_scaled.size() == 0) begin
        report_mismatch("result with no sample outstanding", scaled_if.out_sample, 'x);
      end else begin
        want = expected_scaled.pop_front();
        if (scaled_if.out_sample !== want.pcm)
          report_mismatch("out_sample", scaled_if.out_sample, want.pcm);
        if (scaled_if.out_half_byte !== want.half_byte)
          report_mismatch("out_half_byte", SAMPLE_W'(scaled_if.out_half_byte),
                          SAMPLE_W'(want.half_byte));
        if (scaled_if.out_last !== want.last)
          report_mismatch("out_last", SAMPLE_W'(scaled_if.out_last), SAMPLE_W'(want.last));
        results_checked++;
      end
    end
  end

  initial begin
    pcm_in_t it;
    stream_if.valid        <= 1'b0;
    stream_if.in_sample    <= '0;
    stream_if.start_gain   <= '0;
    stream_if.end_gain     <= '0;
    stream_if.block_frames <= '0;
    stream_if.half_byte    <= 1'b0;
    stream_if.last         <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 23;
    rx_idle_pct = 86;
    for (int r = 0; r < N_ROWS; r++) begin
      send_pcm(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
      directed_count++;
    end

    // One long block of short ramps, so the frame index runs far past the frame count.
    for (int i = 0; i < LONG_RUN + 4; i++) begin
      it.sample = SAMPLE_W'($urandom);
      it.half_byte = 1'b0;
      it.last = (i == LONG_RUN + 3);
      if (i < LONG_RUN) begin
        it.start_gain = GAIN_W'($urandom_range(0, 65535));
        it.end_gain = GAIN_W'($urandom_range(0, 65535));
        it.block_frames = FRAMES_W'($urandom_range(0, 64));
      end else begin
        it.start_gain = (i == LONG_RUN) ? '0 : GAIN_W'($urandom_range(0, 65535));
        it.end_gain = (i == LONG_RUN) ? GAIN_W'(MAX_FRAMES)
                                      : GAIN_W'($urandom_range(0, 65535));
        it.block_frames = (i == LONG_RUN) ? FRAMES_W'(MAX_FRAMES)
                                          : FRAMES_W'($urandom_range(1, 8191));
      end
      send_pcm(it, 1'b0, '0);
      long_count++;
    end

    run_random_phase(23, 86, PHASE_QUOTA, 1'b1, 1'b0);
    run_random_phase(86, 23, PHASE_QUOTA, 1'b0, 1'b0);
    run_random_phase(0, 0, PHASE_QUOTA, 1'b0, 1'b1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d directed, %0d long-block and %0d random samples; %0d results checked",
             directed_count, long_count, random_count, results_checked);
    $display("Covered %0d ramped samples and %0d half bytes under mixed back-pressure",
             ramped_count, half_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
